// ----- hdl/mtg_pkg.sv -----
// shared types, constants and helpers for the mt19937 generator
// no dependencies
`timescale 1ns / 1ps
package mtg_pkg;
    localparam int TW_N = 624;
    localparam int TW_M = 397;
    localparam int KEY_WORDS = 4;
    localparam int IDX_W = 10;
    localparam int KEY_IDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int KEY_CNT_W = $clog2(KEY_WORDS + 1);
    localparam logic [31:0] TW_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TW_UPPER = 32'h80000000;
    localparam logic [31:0] TW_LOWER = 32'h7fffffff;
    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] KEY_MULT_A = 32'd1664525;
    localparam logic [31:0] KEY_MULT_B = 32'd1566083941;
    localparam logic [31:0] KEY_SEED = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [IDX_W-1:0] IDX_EXHAUSTED = IDX_W'(TW_N);
    localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(TW_N + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TW_N - 1);

    typedef enum logic [1:0] {
        REQ_DRAW = 2'd0,
        REQ_SEED = 2'd1,
        REQ_KEY = 2'd2,
        REQ_BOUNDED = 2'd3
    } req_kind_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] hi, input logic [31:0] lo,
                                          input logic [31:0] far);
        logic [31:0] y;
        y = (hi & TW_UPPER) | (lo & TW_LOWER);
        return far ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
    endfunction

    function automatic logic [31:0] span_mask(input logic [31:0] b);
        logic [31:0] u;
        u = b;
        u = u | (u >> 1);
        u = u | (u >> 2);
        u = u | (u >> 4);
        u = u | (u >> 8);
        u = u | (u >> 16);
        return u;
    endfunction
endpackage

// ----- hdl/mtg_ram.sv -----
// generic single-write dual-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module mtg_ram #(
    parameter int DEPTH = 624,
    parameter int WIDTH = 32,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- hdl/mersenne_twister_generator.sv -----
// mt19937 generator top level: request sequencer around the state table ram
// depends on mtg_pkg and mtg_ram
`timescale 1ns / 1ps
// One request at a time. A draw on a ready table returns its word after a table ram
// read, then temper, and the word is registered. The next request is taken once the
// sequencer is back in idle and the word has left, so a stalled word holds off the
// next request. When the table is exhausted the draw first regenerates it, each word
// with a ram read of the next and the far word, then the write. Seeding walks the
// table, one 32x32 multiply per word. The key schedule seeds, then runs two more walks
// of 624 and 623 words, plus a pass through the fix-up state each time the walk wraps.
// A draw before any seeding also seeds with 5489. Bounded draws repeat draws until the
// masked word fits, so their length varies.
module mersenne_twister_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [31:0]         data_word,
    input  logic                key_last,
    input  logic [31:0]         upper_bound,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         random_word
);
    import mtg_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SEED_R = 11'b00000000010,
        ST_SEED_W = 11'b00000000100,
        ST_KEY_R  = 11'b00000001000,
        ST_KEY_W  = 11'b00000010000,
        ST_GEN_R  = 11'b00000100000,
        ST_GEN_W  = 11'b00001000000,
        ST_DRAW_R = 11'b00010000000,
        ST_DRAW_W = 11'b00100000000,
        ST_OUT    = 11'b01000000000,
        ST_FIX    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic keymode_reg, keymode_next;
    logic drawmode_reg, drawmode_next;
    logic bounded_reg, bounded_next;
    logic [31:0] bound_reg, bound_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [KEY_CNT_W-1:0] kcnt_reg, kcnt_next;
    logic [KEY_CNT_W-1:0] klen_reg, klen_next;
    logic [KEY_CNT_W-1:0] kb_reg, kb_next;
    logic [31:0] key_store [KEY_WORDS];
    logic [31:0] rd_a, rd_b;
    logic [31:0] prev_reg, prev_next;
    logic we;
    logic [IDX_W-1:0] waddr, ra, rb;
    logic [31:0] wdata;
    logic in_fire;
    logic [31:0] t;
    logic [IDX_W:0] far_sum;
    logic [IDX_W-1:0] far_idx, nxt_idx;

    mtg_ram #(.DEPTH(TW_N), .WIDTH(32), .AW(IDX_W)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .rdata_a(rd_a), .raddr_b(rb), .rdata_b(rd_b)
    );

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_fire = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign random_word = out_reg;
    assign t = temper(rd_a);
    assign far_sum = {1'b0, ptr_reg} + (IDX_W + 1)'(TW_M);
    assign far_idx = (far_sum >= (IDX_W + 1)'(TW_N)) ? IDX_W'(far_sum - (IDX_W + 1)'(TW_N))
                                                     : far_sum[IDX_W-1:0];
    assign nxt_idx = (ptr_reg == IDX_LAST) ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_fire && req_kind_t'(req_type) == REQ_KEY && kcnt_reg < KEY_CNT_W'(KEY_WORDS))
        begin
            key_store[kcnt_reg[KEY_IDX_W-1:0]] <= data_word;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        keymode_next = keymode_reg;
        drawmode_next = drawmode_reg;
        bounded_next = bounded_reg;
        bound_next = bound_reg;
        mask_next = mask_reg;
        prod_next = prod_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        kcnt_next = kcnt_reg;
        klen_next = klen_reg;
        kb_next = kb_reg;
        prev_next = prev_reg;
        we = 1'b0;
        waddr = ptr_reg;
        wdata = prev_reg;
        ra = ptr_reg;
        rb = nxt_idx;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_kind_t'(req_type))
                        REQ_SEED:
                        begin
                            prev_next = data_word;
                            we = 1'b1;
                            waddr = '0;
                            wdata = data_word;
                            ptr_next = IDX_W'(1);
                            keymode_next = 1'b0;
                            drawmode_next = 1'b0;
                            state_next = ST_SEED_R;
                        end
                        REQ_KEY:
                        begin
                            if (kcnt_reg < KEY_CNT_W'(KEY_WORDS))
                            begin
                                kcnt_next = kcnt_reg + 1'b1;
                            end
                            if (key_last)
                            begin
                                klen_next = (kcnt_reg < KEY_CNT_W'(KEY_WORDS))
                                            ? kcnt_reg + 1'b1 : kcnt_reg;
                                kcnt_next = '0;
                                prev_next = KEY_SEED;
                                we = 1'b1;
                                waddr = '0;
                                wdata = KEY_SEED;
                                ptr_next = IDX_W'(1);
                                keymode_next = 1'b1;
                                drawmode_next = 1'b0;
                                state_next = ST_SEED_R;
                            end
                        end
                        REQ_DRAW, REQ_BOUNDED:
                        begin
                            bounded_next = (req_kind_t'(req_type) == REQ_BOUNDED);
                            bound_next = upper_bound;
                            mask_next = (req_kind_t'(req_type) == REQ_BOUNDED)
                                        ? span_mask(upper_bound) : 32'hffffffff;
                            drawmode_next = 1'b1;
                            state_next = ST_DRAW_R;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRAW_R:
            begin
                if (idx_reg == IDX_UNSEEDED)
                begin
                    prev_next = DEFAULT_SEED;
                    we = 1'b1;
                    waddr = '0;
                    wdata = DEFAULT_SEED;
                    ptr_next = IDX_W'(1);
                    keymode_next = 1'b0;
                    state_next = ST_SEED_R;
                end
                else if (idx_reg == IDX_EXHAUSTED)
                begin
                    ra = '0;
                    ptr_next = '0;
                    state_next = ST_GEN_R;
                end
                else
                begin
                    ra = idx_reg;
                    state_next = ST_DRAW_W;
                end
            end
            ST_DRAW_W:
            begin
                idx_next = idx_reg + 1'b1;
                if ((t & mask_reg) <= bound_reg || !bounded_reg)
                begin
                    out_next = t & mask_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DRAW_R;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            ST_SEED_R:
            begin
                prod_next = SEED_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = ST_SEED_W;
            end
            ST_SEED_W:
            begin
                wdata = prod_reg + 32'(ptr_reg);
                we = 1'b1;
                prev_next = wdata;
                if (ptr_reg == IDX_LAST)
                begin
                    if (keymode_reg)
                    begin
                        ptr_next = IDX_W'(1);
                        kb_next = '0;
                        cnt_next = (TW_N > KEY_WORDS) ? IDX_W'(TW_N) : IDX_W'(klen_reg);
                        phase_next = 1'b0;
                        prev_next = KEY_SEED;
                        state_next = ST_KEY_R;
                    end
                    else if (drawmode_reg)
                    begin
                        ra = '0;
                        ptr_next = '0;
                        state_next = ST_GEN_R;
                    end
                    else
                    begin
                        idx_next = IDX_EXHAUSTED;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = ST_SEED_R;
                end
            end
            ST_KEY_R:
            begin
                ra = ptr_reg;
                prod_next = (prev_reg ^ (prev_reg >> 30)) * (phase_reg ? KEY_MULT_B : KEY_MULT_A);
                state_next = ST_KEY_W;
            end
            ST_KEY_W:
            begin
                if (phase_reg)
                begin
                    wdata = (rd_a ^ prod_reg) - 32'(ptr_reg);
                end
                else
                begin
                    wdata = (rd_a ^ prod_reg) + key_store[kb_reg[KEY_IDX_W-1:0]] + 32'(kb_reg);
                end
                we = 1'b1;
                prev_next = wdata;
                if (!phase_reg)
                begin
                    kb_next = (kb_reg + 1'b1 >= klen_reg) ? '0 : kb_reg + 1'b1;
                end
                if (ptr_reg == IDX_LAST)
                begin
                    ptr_next = IDX_W'(1);
                    state_next = ST_FIX;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = ST_KEY_R;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == IDX_W'(1))
                begin
                    if (phase_reg)
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        cnt_next = IDX_W'(TW_N - 1);
                    end
                end
            end
            ST_FIX:
            begin
                we = 1'b1;
                waddr = '0;
                if (phase_reg && cnt_reg == '0)
                begin
                    wdata = TW_UPPER;
                    idx_next = IDX_EXHAUSTED;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wdata = prev_reg;
                    state_next = ST_KEY_R;
                end
            end
            ST_GEN_R:
            begin
                if (ptr_reg == '0)
                begin
                    prev_next = rd_a;
                end
                ra = nxt_idx;
                rb = far_idx;
                state_next = ST_GEN_W;
            end
            ST_GEN_W:
            begin
                we = 1'b1;
                wdata = twist(prev_reg, rd_a, rd_b);
                prev_next = rd_a;
                ptr_next = nxt_idx;
                state_next = (ptr_reg == IDX_LAST) ? ST_DRAW_R : ST_GEN_R;
                if (ptr_reg == IDX_LAST)
                begin
                    idx_next = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= IDX_UNSEEDED;
            kcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            kcnt_reg <= kcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        phase_reg <= phase_next;
        keymode_reg <= keymode_next;
        drawmode_reg <= drawmode_next;
        bounded_reg <= bounded_next;
        bound_reg <= bound_next;
        mask_reg <= mask_next;
        prod_reg <= prod_next;
        out_reg <= out_next;
        klen_reg <= klen_next;
        kb_reg <= kb_next;
        prev_reg <= prev_next;
    end
endmodule

// ----- sim/mersenne_twister_generator_tb.sv -----
// self-checking testbench for the mt19937 generator: bursty request driver,
// stalling result monitor and a behavioral copy of the generator state
// depends on mtg_pkg and the mersenne_twister_generator rtl
`timescale 1ns / 1ps
module mersenne_twister_generator_tb;
    import mtg_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 6000;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        req_kind_t   kind;
        logic [31:0] word;
        logic        last;
        logic [31:0] bound;
        logic        drain;
    } gen_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_DRAW;
    logic [31:0] data_word = '0;
    logic        key_last = 1'b0;
    logic [31:0] upper_bound = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] random_word;

    gen_req_t    pending_reqs[$];
    logic [31:0] expected_words[$];
    int          error_count = 0;
    int          cycle_count = 0;

    // generator state mirror
    logic [31:0] mt_state[TW_N];
    int unsigned mt_pos = TW_N + 1;
    logic [31:0] key_words[KEY_WORDS];
    int unsigned key_n = 0;

    mersenne_twister_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .data_word(data_word),
        .key_last(key_last),
        .upper_bound(upper_bound),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .random_word(random_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic void seed_state(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int n = 1; n < TW_N; n++)
        begin
            p = mt_state[n-1];
            mt_state[n] = SEED_MULT * (p ^ (p >> 30)) + 32'(n);
        end
        mt_pos = TW_N;
    endfunction

    function automatic void run_key_schedule(input int unsigned len);
        int unsigned a;
        int unsigned b;
        logic [31:0] p;
        a = 1;
        b = 0;
        seed_state(KEY_SEED);
        for (int k = (TW_N > len) ? TW_N : len; k != 0; k--)
        begin
            p = mt_state[a-1];
            mt_state[a] = (mt_state[a] ^ ((p ^ (p >> 30)) * KEY_MULT_A))
                          + key_words[b] + 32'(b);
            a++;
            b++;
            if (a >= TW_N)
            begin
                mt_state[0] = mt_state[TW_N-1];
                a = 1;
            end
            if (b >= len)
                b = 0;
        end
        for (int k = TW_N - 1; k != 0; k--)
        begin
            p = mt_state[a-1];
            mt_state[a] = (mt_state[a] ^ ((p ^ (p >> 30)) * KEY_MULT_B)) - 32'(a);
            a++;
            if (a >= TW_N)
            begin
                mt_state[0] = mt_state[TW_N-1];
                a = 1;
            end
        end
        mt_state[0] = 32'h80000000;
        mt_pos = TW_N;
    endfunction

    function automatic logic [31:0] mix_entry(input logic [31:0] hi, input logic [31:0] lo,
                                              input logic [31:0] far);
        logic [31:0] y;
        y = {hi[31], lo[30:0]};
        return far ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
    endfunction

    function automatic logic [31:0] next_tempered();
        logic [31:0] y;
        if (mt_pos >= TW_N)
        begin
            if (mt_pos != TW_N)
                seed_state(DEFAULT_SEED);
            for (int n = 0; n < TW_N - 1; n++)
                mt_state[n] = mix_entry(mt_state[n], mt_state[n+1], mt_state[(n+TW_M)%TW_N]);
            mt_state[TW_N-1] = mix_entry(mt_state[TW_N-1], mt_state[0], mt_state[TW_M-1]);
            mt_pos = 0;
        end
        y = mt_state[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void predict_request(input gen_req_t r);
        logic [31:0] span;
        logic [31:0] v;
        case (r.kind)
            REQ_SEED: seed_state(r.word);
            REQ_KEY:
            begin
                if (key_n < KEY_WORDS)
                begin
                    key_words[key_n] = r.word;
                    key_n++;
                end
                if (r.last)
                begin
                    run_key_schedule(key_n);
                    key_n = 0;
                end
            end
            REQ_DRAW: expected_words.push_back(next_tempered());
            default:
            begin
                span = r.bound;
                for (int s = 1; s < 32; s = s * 2)
                    span = span | (span >> s);
                do
                    v = next_tempered() & span;
                while (v > r.bound);
                expected_words.push_back(v);
            end
        endcase
    endfunction

    function automatic void push_req(input req_kind_t kind, input logic [31:0] word,
                                     input logic last, input logic [31:0] bound,
                                     input logic drain = 1'b0);
        gen_req_t r;
        r.kind = kind;
        r.word = word;
        r.last = last;
        r.bound = bound;
        r.drain = drain;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [31:0] rand_bound();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // driver: bursts of requests separated by random gaps
    int       burst_left = 0;
    int       gap_left = 0;
    gen_req_t cur_req;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(cur_req);
                if (burst_left > 0)
                    burst_left--;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_valid && !in_stall && burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain &&
                           (expected_words.size() > 0 || (in_valid && !in_stall))))
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_req.kind;
                    data_word <= cur_req.word;
                    key_last <= cur_req.last;
                    upper_bound <= cur_req.bound;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall pattern, one long hold
    int stall_pct = 0;
    int hold_left = 0;
    int words_seen = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected random_word", random_word, 32'h0);
                else if (random_word !== expected_words[0])
                    report_mismatch("random_word", random_word, expected_words.pop_front());
                else
                    void'(expected_words.pop_front());
            end
            if (cycle_count % 256 == 0)
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            if (!hold_done && words_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[mersenne_twister_generator] ERROR");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int nkeys;
        // draw before seeding, bounded extremes
        push_req(REQ_DRAW, 32'hffffffff, 1'b1, 32'hffffffff);
        push_req(REQ_BOUNDED, 32'h0, 1'b0, 32'h0);
        push_req(REQ_BOUNDED, 32'h0, 1'b1, 32'hffffffff);
        push_req(REQ_BOUNDED, 32'hffffffff, 1'b0, 32'h1);
        push_req(REQ_BOUNDED, 32'h0, 1'b0, 32'h80000000);
        push_req(REQ_SEED, 32'h0, 1'b1, 32'hffffffff);
        push_req(REQ_DRAW, 32'h0, 1'b0, 32'h0);
        push_req(REQ_SEED, 32'hffffffff, 1'b0, 32'h0);
        push_req(REQ_DRAW, 32'h0, 1'b0, 32'h0);
        push_req(REQ_BOUNDED, 32'h0, 1'b0, 32'h5);
        // single key word
        push_req(REQ_KEY, 32'hffffffff, 1'b1, 32'h0);
        push_req(REQ_DRAW, 32'h0, 1'b0, 32'h0);
        // five words: store overflows, dropped word starts the schedule
        push_req(REQ_KEY, 32'h00000123, 1'b0, 32'hffffffff);
        push_req(REQ_KEY, 32'h00000234, 1'b0, 32'h0);
        push_req(REQ_KEY, 32'h00000345, 1'b0, 32'h0);
        push_req(REQ_KEY, 32'h00000456, 1'b0, 32'h0);
        push_req(REQ_KEY, 32'hdeadbeef, 1'b1, 32'h0);
        push_req(REQ_DRAW, 32'h0, 1'b0, 32'h0);
        push_req(REQ_BOUNDED, 32'h0, 1'b0, 32'h7fffffff);
        push_req(REQ_SEED, 32'd5489, 1'b0, 32'h0, 1'b1);
        push_req(REQ_DRAW, 32'h0, 1'b0, 32'h0);

        for (int i = 0; i < 1080; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_req(REQ_DRAW, $urandom, $urandom_range(0, 1), $urandom, (i % 400) == 399);
            else if (pick < 90)
                push_req(REQ_BOUNDED, $urandom, $urandom_range(0, 1), rand_bound());
            else if (pick < 92)
                push_req(REQ_SEED, $urandom, $urandom_range(0, 1), $urandom);
            else if (pick < 94)
            begin
                nkeys = $urandom_range(1, 6);
                for (int k = 0; k < nkeys; k++)
                    push_req(REQ_KEY, $urandom, (k == nkeys - 1) && ($urandom_range(0, 4) != 0),
                             $urandom);
            end
            else if (pick < 96)
                push_req(REQ_KEY, $urandom, 1'b0, $urandom);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !in_valid && expected_words.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[mersenne_twister_generator] OK");
        else
            $display("[mersenne_twister_generator] ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/mtg_pkg.sv
hdl/mtg_ram.sv
hdl/mersenne_twister_generator.sv
sim/mersenne_twister_generator_tb.sv
